>>> hdl/afd_pkg.sv
// Package with the shared types and constants of the API frame deframer.
`default_nettype none
package afd_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] GOOD_SUM   = 8'hFF;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_API     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_API     = 3'd1,
        EV_PAYLOAD = 3'd2,
        EV_GOOD    = 3'd3,
        EV_BADSUM  = 3'd4,
        EV_ZEROLEN = 3'd5
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  data_byte;
        logic [31:0] skipped_count;
    } result_t;

endpackage
`default_nettype wire

>>> hdl/api_frame_deframer.sv
// Top level of the API frame deframer: byte parser followed by a skid output stage.
//
// Input channel: one received byte per item on rx_byte, qualified by in_valid
// and held off by in_stall. Output channel: one result item per input byte on
// event_res, data_byte and skipped_count, qualified by out_valid and held off
// by out_stall.
// The parser hunts for the 0x7E delimiter, reads a big-endian 16-bit length,
// the API identifier, length-1 payload bytes and a checksum byte. API and
// payload bytes are passed on as they arrive; the checksum byte reports frame
// good or bad checksum, and a zero length is reported on the low length byte.
// The result of an accepted byte is formed combinationally and registered in the
// output register, or in the skid stage while the output is stalled. Throughput
// is one byte per cycle while in_stall is low.
// Reset clears the parser to hunting, the skip count to zero and both output
// stages to empty. When the receiver stalls, the output register holds its
// item and one more byte is caught in the skid stage; in_stall then rises
// until the output drains.
`default_nettype none
module api_frame_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_res,
    output logic [7:0]       data_byte,
    output logic [31:0]      skipped_count
);
    import afd_pkg::*;

    logic    take;
    logic    full;
    result_t core_result;
    result_t out_data;

    assign in_stall = full;
    assign take     = in_valid && !full;

    afd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .result  (core_result)
    );

    afd_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .load_data (core_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign event_res     = out_data.event_res;
    assign data_byte     = out_data.data_byte;
    assign skipped_count = out_data.skipped_count;

endmodule
`default_nettype wire

>>> hdl/afd_core.sv
// Parser state registers and the next-state logic that turns one byte into one result.
`default_nettype none
module afd_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      rx_byte,
    output afd_pkg::result_t     result
);
    import afd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] skip_reg, skip_next;
    event_t      event_next;
    logic [15:0] remaining_dec;

    assign remaining_dec = remaining_reg - 16'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        skip_next      = skip_reg;
        event_next     = EV_NONE;
        case (phase_reg)
            PH_LEN_HI:
            begin
                remaining_next = {rx_byte, 8'h00};
                phase_next     = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                remaining_next = {remaining_reg[15:8], rx_byte};
                if ({remaining_reg[15:8], rx_byte} == 16'd0)
                begin
                    event_next = EV_ZEROLEN;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_API;
                end
            end
            PH_API, PH_PAYLOAD:
            begin
                if (phase_reg == PH_API)
                begin
                    sum_next   = rx_byte;
                    event_next = EV_API;
                end
                else
                begin
                    sum_next   = sum_reg + rx_byte;
                    event_next = EV_PAYLOAD;
                end
                remaining_next = remaining_dec;
                phase_next     = (remaining_dec == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_CHECK:
            begin
                sum_next   = sum_reg + rx_byte;
                event_next = ((sum_reg + rx_byte) == GOOD_SUM) ? EV_GOOD : EV_BADSUM;
                phase_next = PH_HUNT;
            end
            default:
            begin
                if (rx_byte == DELIM_BYTE)
                begin
                    phase_next = PH_LEN_HI;
                end
                else
                begin
                    phase_next = PH_HUNT;
                    if (skip_reg != 32'hFFFF_FFFF)
                    begin
                        skip_next = skip_reg + 32'd1;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        result.event_res     = event_next;
        result.data_byte     = rx_byte;
        result.skipped_count = skip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= 16'd0;
            sum_reg       <= 8'd0;
            skip_reg      <= 32'd0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            skip_reg      <= skip_next;
        end
    end

    a_check_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECK |-> remaining_reg == 16'd0)
        else $error("checksum phase entered with bytes still to come");

    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_API || phase_reg == PH_PAYLOAD) |-> remaining_reg != 16'd0)
        else $error("frame body phase with no bytes left");

    a_skip_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> skip_reg >= $past(skip_reg))
        else $error("skip count decreased");

endmodule
`default_nettype wire

>>> hdl/afd_skid.sv
// Output register with a skid stage so the input side keeps moving while a result waits.
`default_nettype none
module afd_skid (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire afd_pkg::result_t load_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output afd_pkg::result_t      out_data
);
    import afd_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || load;
            skid_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : load_data;
        end
        if (!out_free && load)
        begin
            skid_data_reg <= load_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds an item while the output register is empty");

    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("item accepted during a stall was not kept");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled output item changed or was dropped");

endmodule
`default_nettype wire
